/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the tokenizer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clk edge, masked while reset is asserted
`define QFT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every rising clk edge, reset included
`define QFT_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/qft_pkg.sv */
// ----------------------------------------------------------------------------
// qft_pkg
// Types and character constants shared by the quoted field tokenizer.
// ----------------------------------------------------------------------------
package qft_pkg;

	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_LF      = 8'h0A;
	localparam logic [7:0] CH_CR      = 8'h0D;
	localparam logic [7:0] CH_LBRACE  = 8'h7B;
	localparam logic [7:0] CH_RBRACE  = 8'h7D;
	localparam logic [7:0] CH_DQUOTE  = 8'h22;
	localparam logic [7:0] CH_SQUOTE  = 8'h27;
	localparam logic [7:0] CH_BSLASH  = 8'h5C;

	typedef enum logic [3:0] {
		MODE_IDLE = 4'b0001,
		MODE_BARE = 4'b0010,
		MODE_DQ   = 4'b0100,
		MODE_SQ   = 4'b1000
	} qft_mode_t;

	typedef struct packed {
		qft_mode_t mode;
		logic      escape_pending;
		logic      field_has_chars;
		logic      start_emitted;
	} qft_flags_t;

	localparam qft_flags_t FLAGS_IDLE = '{
		mode: MODE_IDLE, escape_pending: 1'b0, field_has_chars: 1'b0, start_emitted: 1'b0
	};

	typedef struct packed {
		logic [7:0] byte_value;
		logic       end_of_input;
	} qft_in_t;

	typedef struct packed {
		logic              has_char;
		logic [7:0]        char_value;
		logic              token_start;
		logic              token_end;
		logic              token_valid;
		logic              within_quotes;
		logic signed [15:0] nesting_depth;
		logic              last;
	} qft_out_t;

	function automatic qft_out_t mk_res(input logic hc, input logic [7:0] ch,
			input logic st, input logic en, input logic va, input logic q,
			input logic signed [15:0] nd);
		qft_out_t r;
		r.has_char      = hc;
		r.char_value    = hc ? ch : 8'h00;
		r.token_start   = st;
		r.token_end     = en;
		r.token_valid   = va;
		r.within_quotes = q;
		r.nesting_depth = nd;
		r.last          = 1'b0;
		return r;
	endfunction

endpackage

/* rtl/core/qft_step.sv */
// ----------------------------------------------------------------------------
// qft_step
// Next-state and result logic for one byte: up to two result items.
// ----------------------------------------------------------------------------
module qft_step #(
	parameter int DEPTH_BITS = 16
) (
	input  qft_pkg::qft_in_t          data,
	input  qft_pkg::qft_flags_t       flags,
	input  logic signed [DEPTH_BITS-1:0] cnt,
	output qft_pkg::qft_flags_t       flags_d,
	output logic signed [DEPTH_BITS-1:0] cnt_d,
	output qft_pkg::qft_out_t         res0,
	output qft_pkg::qft_out_t         res1,
	output logic [1:0]                nres
);

	localparam logic signed [DEPTH_BITS-1:0] MaxCnt = {1'b0, {(DEPTH_BITS-1){1'b1}}};
	localparam logic signed [DEPTH_BITS-1:0] MinCnt = {1'b1, {(DEPTH_BITS-1){1'b0}}};
	localparam logic signed [DEPTH_BITS-1:0] CntOne = {{(DEPTH_BITS-1){1'b0}}, 1'b1};

	logic [7:0]                   c;
	logic                         is_space, is_brace, is_quote, quoted;
	logic signed [DEPTH_BITS-1:0] cnt_brace;
	logic signed [15:0]           nd_old, nd_new;
	logic                         open_push;
	qft_pkg::qft_out_t            open_res, close_res;
	qft_pkg::qft_flags_t          open_flags;
	logic signed [DEPTH_BITS-1:0] open_cnt;
	logic [7:0]                   qc;
	logic                         push0, push1;

	assign c        = data.byte_value;
	assign is_space = (c == qft_pkg::CH_SPACE) || (c == qft_pkg::CH_TAB) ||
	                  (c == qft_pkg::CH_LF) || (c == qft_pkg::CH_CR);
	assign is_brace = (c == qft_pkg::CH_LBRACE) || (c == qft_pkg::CH_RBRACE);
	assign is_quote = (c == qft_pkg::CH_DQUOTE) || (c == qft_pkg::CH_SQUOTE);
	assign quoted   = (flags.mode == qft_pkg::MODE_DQ) || (flags.mode == qft_pkg::MODE_SQ);
	assign qc       = (flags.mode == qft_pkg::MODE_DQ) ? qft_pkg::CH_DQUOTE : qft_pkg::CH_SQUOTE;

	// saturating brace count
	always_comb begin
		if (c == qft_pkg::CH_LBRACE) begin
			cnt_brace = (cnt != MaxCnt) ? cnt + CntOne : cnt;
		end else begin
			cnt_brace = (cnt != MinCnt) ? cnt - CntOne : cnt;
		end
	end

	assign nd_old = 16'(cnt);
	assign nd_new = 16'(cnt_brace);

	assign close_res = qft_pkg::mk_res(1'b0, 8'h00, !flags.start_emitted, 1'b1,
	                                   flags.field_has_chars, quoted, nd_old);

	// opening of a new field on byte c
	always_comb begin
		open_push  = 1'b0;
		open_res   = qft_pkg::mk_res(1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, nd_old);
		open_flags = qft_pkg::FLAGS_IDLE;
		open_cnt   = cnt;
		if (is_brace) begin
			open_push = 1'b1;
			open_cnt  = cnt_brace;
			open_res  = qft_pkg::mk_res(1'b1, c, 1'b1, 1'b1, 1'b1, 1'b0, nd_new);
		end else if (c == qft_pkg::CH_DQUOTE) begin
			open_flags.mode = qft_pkg::MODE_DQ;
		end else if (c == qft_pkg::CH_SQUOTE) begin
			open_flags.mode = qft_pkg::MODE_SQ;
		end else begin
			open_push                  = 1'b1;
			open_flags.mode            = qft_pkg::MODE_BARE;
			open_flags.start_emitted   = 1'b1;
			open_flags.field_has_chars = 1'b1;
			open_res = qft_pkg::mk_res(1'b1, c, 1'b1, 1'b0, 1'b0, 1'b0, nd_old);
		end
	end

	always_comb begin
		flags_d = flags;
		cnt_d   = cnt;
		push0   = 1'b0;
		push1   = 1'b0;
		res0    = close_res;
		res1    = open_res;
		if (data.end_of_input) begin
			if (flags.mode != qft_pkg::MODE_IDLE) begin
				push0   = 1'b1;
				flags_d = qft_pkg::FLAGS_IDLE;
			end
		end else begin
			unique case (flags.mode)
				qft_pkg::MODE_IDLE: begin
					if (!is_space) begin
						push0   = open_push;
						res0    = open_res;
						flags_d = open_flags;
						cnt_d   = open_cnt;
					end
				end
				qft_pkg::MODE_BARE: begin
					if (is_space) begin
						push0   = 1'b1;
						flags_d = qft_pkg::FLAGS_IDLE;
					end else if (is_brace || is_quote) begin
						// word ends, the brace or quote opens the next field
						push0   = 1'b1;
						push1   = open_push;
						flags_d = open_flags;
						cnt_d   = open_cnt;
					end else begin
						push0 = 1'b1;
						res0  = qft_pkg::mk_res(1'b1, c, !flags.start_emitted, 1'b0,
						                        1'b0, 1'b0, nd_old);
						flags_d.start_emitted   = 1'b1;
						flags_d.field_has_chars = 1'b1;
					end
				end
				qft_pkg::MODE_DQ, qft_pkg::MODE_SQ: begin
					if (c == qft_pkg::CH_BSLASH && !flags.escape_pending) begin
						flags_d.escape_pending = 1'b1;
					end else if ((c == qft_pkg::CH_BSLASH && flags.mode == qft_pkg::MODE_DQ)
					             || (c == qc && flags.escape_pending)) begin
						push0 = 1'b1;
						res0  = qft_pkg::mk_res(1'b1, c, !flags.start_emitted, 1'b0,
						                        1'b0, 1'b1, nd_old);
						flags_d.escape_pending  = 1'b0;
						flags_d.start_emitted   = 1'b1;
						flags_d.field_has_chars = 1'b1;
					end else if (c == qc) begin
						push0 = 1'b1;
						res0  = qft_pkg::mk_res(1'b0, 8'h00, !flags.start_emitted, 1'b1,
						                        1'b1, 1'b1, nd_old);
						flags_d = qft_pkg::FLAGS_IDLE;
					end else begin
						push0 = 1'b1;
						if (flags.escape_pending) begin
							// unknown escape: keep the backslash, then the byte
							push1 = 1'b1;
							res0  = qft_pkg::mk_res(1'b1, qft_pkg::CH_BSLASH,
							                        !flags.start_emitted, 1'b0, 1'b0, 1'b1, nd_old);
							res1  = qft_pkg::mk_res(1'b1, c, 1'b0, 1'b0, 1'b0, 1'b1, nd_old);
						end else begin
							res0  = qft_pkg::mk_res(1'b1, c, !flags.start_emitted, 1'b0,
							                        1'b0, 1'b1, nd_old);
						end
						flags_d.escape_pending  = 1'b0;
						flags_d.start_emitted   = 1'b1;
						flags_d.field_has_chars = 1'b1;
					end
				end
				default: begin
					flags_d = qft_pkg::FLAGS_IDLE;
				end
			endcase
		end
		res0.last = !push1;
		res1.last = 1'b1;
	end

	assign nres = {1'b0, push0} + {1'b0, push1};

endmodule

/* rtl/core/quoted_field_tokenizer.sv */
// An item waits in in_s1 until the result queue has room; its results are then
// registered into the queue and offered from there. Throughput: one input item per
// cycle while the queue has room; the output moves one result per cycle, so an item
// with two results (word closed by a brace, unknown escape) needs two output transfers.
// The limit is the single output port fed from a two-entry result queue.
// Reset (arst_n low, asynchronous): between fields, no escape, count zero, queue empty.
// ----------------------------------------------------------------------------
// quoted_field_tokenizer
// Splits a byte stream into bare, quoted and brace fields, one byte per item.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module quoted_field_tokenizer #(
	parameter int DEPTH_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  qft_pkg::qft_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output qft_pkg::qft_out_t out_data
);

	qft_pkg::qft_in_t             in_s1;
	logic                         vld_s1;
	qft_pkg::qft_flags_t          flags_q, flags_d;
	logic signed [DEPTH_BITS-1:0] cnt_q, cnt_d;
	qft_pkg::qft_out_t            res0, res1;
	logic [1:0]                   nres;

	qft_pkg::qft_out_t            que_q [2];
	qft_pkg::qft_out_t            que_d [2];
	logic [1:0]                   fill_q, fill_d;
	logic [1:0]                   fill_pop;
	logic                         pop, adv;

	qft_step #(
		.DEPTH_BITS(DEPTH_BITS)
	) u_step (
		.data    (in_s1),
		.flags   (flags_q),
		.cnt     (cnt_q),
		.flags_d (flags_d),
		.cnt_d   (cnt_d),
		.res0    (res0),
		.res1    (res1),
		.nres    (nres)
	);

	assign out_valid = (fill_q != 2'd0);
	assign out_data  = que_q[0];
	assign pop       = out_valid && out_ready;
	assign fill_pop  = fill_q - {1'b0, pop};
	assign adv       = vld_s1 && (({1'b0, fill_pop} + {1'b0, nres}) <= 3'd2);
	assign in_ready  = !vld_s1 || adv;

	always_comb begin
		que_d  = que_q;
		fill_d = fill_pop;
		if (pop) begin
			que_d[0] = que_q[1];
		end
		if (adv) begin
			if (nres != 2'd0) begin
				que_d[fill_pop[0]] = res0;
			end
			if (nres == 2'd2) begin
				que_d[1] = res1;
			end
			fill_d = fill_pop + nres;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			flags_q <= qft_pkg::FLAGS_IDLE;
			cnt_q   <= '0;
			fill_q  <= 2'd0;
		end else begin
			fill_q <= fill_d;
			if (in_ready) begin
				vld_s1 <= in_valid;
			end
			if (adv) begin
				flags_q <= flags_d;
				cnt_q   <= cnt_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			in_s1 <= in_data;
		end
		que_q <= que_d;
	end

	`QFT_ASSERT(a_fill_bound, fill_q <= 2'd2, "result queue overfilled")
	`QFT_ASSERT(a_hold_s1, vld_s1 && !adv |=> vld_s1 && $stable(in_s1), "stalled byte lost")
	`QFT_ASSERT(a_eoi_idle, adv && in_s1.end_of_input |=> flags_q == qft_pkg::FLAGS_IDLE,
		"field left open after end of input")
	`QFT_ASSERT(a_end_char, out_valid && out_data.token_end && out_data.has_char
		|-> out_data.token_start, "end result with character is not a brace")
	`QFT_ASSERT_ALWAYS(a_reset_empty, $rose(arst_n) |-> fill_q == 2'd0 && !vld_s1,
		"queue not empty out of reset")

endmodule

/* test/quoted_field_tokenizer_test.sv */
// ----------------------------------------------------------------------------
// quoted_field_tokenizer_test
// Self-checking bench for the tokenizer. Text bytes go in over the input
// handshake; a behavioural copy of the field scanner predicts each result item,
// which is checked field by field against the output handshake.
// ----------------------------------------------------------------------------
module quoted_field_tokenizer_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 3000;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	qft_pkg::qft_in_t  in_data;
	logic              out_valid;
	logic              out_ready;
	qft_pkg::qft_out_t out_data;

	int send_idle_pct;
	int recv_idle_pct;
	int items_sent;
	int results_seen;
	int errors;
	int stall_cycles;

	// scanner copy
	qft_pkg::qft_mode_t tok_mode;
	logic               tok_escape;
	logic               tok_has_chars;
	logic               tok_started;
	logic signed [15:0] tok_depth;
	qft_pkg::qft_out_t  pending_results[$];

	quoted_field_tokenizer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------
	function automatic logic is_space(logic [7:0] c);
		return c == qft_pkg::CH_SPACE || c == qft_pkg::CH_TAB || c == qft_pkg::CH_LF
			|| c == qft_pkg::CH_CR;
	endfunction

	function automatic logic starts_field(logic [7:0] c);
		return c == qft_pkg::CH_LBRACE || c == qft_pkg::CH_RBRACE
			|| c == qft_pkg::CH_DQUOTE || c == qft_pkg::CH_SQUOTE;
	endfunction

	function automatic void push_result(logic hc, logic [7:0] ch, logic st, logic en,
			logic va);
		qft_pkg::qft_out_t r;
		r.has_char      = hc;
		r.char_value    = hc ? ch : 8'h00;
		r.token_start   = st;
		r.token_end     = en;
		r.token_valid   = va;
		r.within_quotes = (tok_mode == qft_pkg::MODE_DQ) || (tok_mode == qft_pkg::MODE_SQ);
		r.nesting_depth = tok_depth;
		r.last          = 1'b0;
		pending_results.push_back(r);
	endfunction

	function automatic void emit_char(logic [7:0] c);
		push_result(1'b1, c, !tok_started, 1'b0, 1'b0);
		tok_started   = 1'b1;
		tok_has_chars = 1'b1;
	endfunction

	function automatic void close_field(logic valid);
		push_result(1'b0, 8'h00, !tok_started, 1'b1, valid);
		tok_mode      = qft_pkg::MODE_IDLE;
		tok_escape    = 1'b0;
		tok_has_chars = 1'b0;
		tok_started   = 1'b0;
	endfunction

	function automatic void open_field(logic [7:0] c);
		tok_escape    = 1'b0;
		tok_has_chars = 1'b0;
		tok_started   = 1'b0;
		if (c == qft_pkg::CH_LBRACE || c == qft_pkg::CH_RBRACE) begin
			if (c == qft_pkg::CH_LBRACE) begin
				if (tok_depth != 16'sh7FFF) tok_depth = tok_depth + 16'sd1;
			end else begin
				if (tok_depth != 16'sh8000) tok_depth = tok_depth - 16'sd1;
			end
			tok_mode = qft_pkg::MODE_IDLE;
			push_result(1'b1, c, 1'b1, 1'b1, 1'b1);
		end else if (c == qft_pkg::CH_DQUOTE) begin
			tok_mode = qft_pkg::MODE_DQ;
		end else if (c == qft_pkg::CH_SQUOTE) begin
			tok_mode = qft_pkg::MODE_SQ;
		end else begin
			tok_mode = qft_pkg::MODE_BARE;
			emit_char(c);
		end
	endfunction

	function automatic void tokenize_byte(qft_pkg::qft_in_t it);
		int         first;
		logic [7:0] c;
		logic [7:0] qc;
		first = pending_results.size();
		c     = it.byte_value;
		if (it.end_of_input) begin
			if (tok_mode != qft_pkg::MODE_IDLE) close_field(tok_has_chars);
		end else if (tok_mode == qft_pkg::MODE_IDLE) begin
			if (!is_space(c)) open_field(c);
		end else if (tok_mode == qft_pkg::MODE_BARE) begin
			if (is_space(c)) begin
				close_field(tok_has_chars);
			end else if (starts_field(c)) begin
				close_field(tok_has_chars);
				open_field(c);
			end else begin
				emit_char(c);
			end
		end else begin
			qc = (tok_mode == qft_pkg::MODE_DQ) ? qft_pkg::CH_DQUOTE : qft_pkg::CH_SQUOTE;
			if (c == qft_pkg::CH_BSLASH && !tok_escape) begin
				tok_escape = 1'b1;
			end else if (c == qft_pkg::CH_BSLASH && tok_mode == qft_pkg::MODE_DQ) begin
				tok_escape = 1'b0;
				emit_char(c);
			end else if (c == qc) begin
				if (tok_escape) begin
					tok_escape = 1'b0;
					emit_char(c);
				end else begin
					close_field(1'b1);
				end
			end else begin
				// unknown escape keeps its backslash
				if (tok_escape) begin
					tok_escape = 1'b0;
					emit_char(qft_pkg::CH_BSLASH);
				end
				emit_char(c);
			end
		end
		if (pending_results.size() > first)
			pending_results[pending_results.size() - 1].last = 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------
	task automatic report_mismatch(string msg);
		errors++;
		$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	task automatic check_field(string name, int got, int want);
		if (got != want)
			report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
				results_seen, name, got, want));
	endtask

	task automatic check_result(qft_pkg::qft_out_t got);
		qft_pkg::qft_out_t want;
		if (pending_results.size() == 0) begin
			report_mismatch($sformatf("result %0d arrived with nothing expected",
				results_seen));
		end else begin
			want = pending_results.pop_front();
			check_field("has_char", got.has_char, want.has_char);
			check_field("char_value", got.char_value, want.char_value);
			check_field("token_start", got.token_start, want.token_start);
			check_field("token_end", got.token_end, want.token_end);
			check_field("token_valid", got.token_valid, want.token_valid);
			check_field("within_quotes", got.within_quotes, want.within_quotes);
			check_field("nesting_depth", got.nesting_depth, want.nesting_depth);
			check_field("last", got.last, want.last);
		end
		results_seen++;
	endtask

	// prediction before checking, so a fast result never overtakes its item
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) tokenize_byte(in_data);
			if (out_valid && out_ready) check_result(out_data);
			if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
			else stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	task automatic send_item(input qft_pkg::qft_in_t item);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	task automatic send_byte(input logic [7:0] b);
		qft_pkg::qft_in_t it;
		it.byte_value   = b;
		it.end_of_input = 1'b0;
		send_item(it);
	endtask

	// byte travels along but is ignored
	task automatic send_eoi(input logic [7:0] junk);
		qft_pkg::qft_in_t it;
		it.byte_value   = junk;
		it.end_of_input = 1'b1;
		send_item(it);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [7:0] pick_space();
		case ($urandom_range(0, 3))
			0: return qft_pkg::CH_SPACE;
			1: return qft_pkg::CH_TAB;
			2: return qft_pkg::CH_LF;
			default: return qft_pkg::CH_CR;
		endcase
	endfunction

	function automatic logic [7:0] pick_word_char();
		if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
		return 8'($urandom_range(33, 126));
	endfunction

	function automatic logic [7:0] pick_escaped();
		case ($urandom_range(0, 3))
			0: return qft_pkg::CH_BSLASH;
			1: return qft_pkg::CH_DQUOTE;
			2: return qft_pkg::CH_SQUOTE;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic send_quoted();
		logic [7:0] q;
		q = $urandom_range(0, 1) ? qft_pkg::CH_DQUOTE : qft_pkg::CH_SQUOTE;
		send_byte(q);
		repeat ($urandom_range(0, 6)) begin
			if ($urandom_range(0, 3) == 0) begin
				send_byte(qft_pkg::CH_BSLASH);
				send_byte(pick_escaped());
			end else begin
				send_byte(pick_word_char());
			end
		end
		case ($urandom_range(0, 11))
			0: send_eoi(8'($urandom_range(0, 255)));
			1: begin
				send_byte(qft_pkg::CH_BSLASH);
				send_eoi(8'($urandom_range(0, 255)));
			end
			2: ; // left open, the next field runs into it
			default: send_byte(q);
		endcase
	endtask

	task automatic send_random_field();
		case ($urandom_range(0, 9))
			0, 1: repeat ($urandom_range(1, 3)) send_byte(pick_space());
			2: send_byte($urandom_range(0, 1) ? qft_pkg::CH_LBRACE : qft_pkg::CH_RBRACE);
			3, 4: repeat ($urandom_range(1, 6)) send_byte(pick_word_char());
			5, 6, 7: send_quoted();
			8: send_eoi(8'($urandom_range(0, 255)));
			default: send_byte(8'($urandom_range(0, 255)));
		endcase
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	task automatic test_separators();
		send_byte("a");
		send_byte(qft_pkg::CH_SPACE);
		send_byte(qft_pkg::CH_TAB);
		send_byte(qft_pkg::CH_CR);
		send_byte(qft_pkg::CH_LF);
	endtask

	// ends inside a double-quoted field opened by the final quote
	task automatic test_bare_words();
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(qft_pkg::CH_LBRACE);
		send_byte("w");
		send_byte(qft_pkg::CH_DQUOTE);
	endtask

	task automatic test_double_quotes();
		send_byte(qft_pkg::CH_BSLASH);
		send_byte(qft_pkg::CH_BSLASH);
		send_byte(qft_pkg::CH_BSLASH);
		send_byte(qft_pkg::CH_DQUOTE);
		send_byte(qft_pkg::CH_BSLASH);
		send_byte("n");
		send_byte(qft_pkg::CH_DQUOTE);
	endtask

	task automatic test_single_quotes();
		send_byte(qft_pkg::CH_SQUOTE);
		send_byte(qft_pkg::CH_BSLASH);
		send_byte(qft_pkg::CH_BSLASH);
		send_byte(qft_pkg::CH_BSLASH);
		send_byte(qft_pkg::CH_SQUOTE);
		send_byte(qft_pkg::CH_SQUOTE);
	endtask

	task automatic test_unclosed_fields();
		send_byte(qft_pkg::CH_DQUOTE);
		send_byte(qft_pkg::CH_BSLASH);
		send_eoi(8'h00);
		send_byte("v");
		send_eoi(8'hFF);
		send_eoi(8'h5A);
		send_byte(qft_pkg::CH_RBRACE);
	endtask

	task automatic test_random_stream(input int count);
		int stop;
		stop = items_sent + count;
		while (items_sent < stop) begin
			send_random_field();
			if ($urandom_range(0, 59) == 0) drain_results();
		end
	endtask

	// drives the count twelve below its starting value, then walks it back up
	task automatic test_depth_walk();
		repeat (12) send_byte(qft_pkg::CH_LBRACE);
		repeat (24) send_byte(qft_pkg::CH_RBRACE);
		repeat (12) send_byte(qft_pkg::CH_LBRACE);
	endtask

	initial begin
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		in_data       = '0;
		out_ready     = 1'b0;
		send_idle_pct = 20;
		recv_idle_pct = 86;
		items_sent    = 0;
		results_seen  = 0;
		errors        = 0;
		stall_cycles  = 0;
		tok_mode      = qft_pkg::MODE_IDLE;
		tok_escape    = 1'b0;
		tok_has_chars = 1'b0;
		tok_started   = 1'b0;
		tok_depth     = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_separators();
		test_bare_words();
		test_double_quotes();
		test_single_quotes();
		test_unclosed_fields();
		drain_results();
		test_random_stream(530);
		drain_results();

		send_idle_pct = 86;
		recv_idle_pct = 20;
		test_random_stream(530);
		drain_results();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_stream(540);
		test_depth_walk();
		drain_results();
		repeat (8) @(posedge clk);

		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
